### hw/rtl/tsd_pkg.sv
// Package for the tar stream deframer: block geometry, header field offsets,
// result kinds, parse states and the transfer structs. No dependencies.
`timescale 1ns / 1ps

package tsd_pkg;

	localparam int BLOCK_LEN  = 512;
	localparam int OFF_W      = 9;
	localparam int SIZE_START = 124;
	localparam int SIZE_LEN   = 12;
	localparam int SUM_START  = 148;
	localparam int SUM_END    = 155;
	localparam logic [7:0] SPACE_CODE = 8'h20;

	localparam int SIZE_W = 36;
	localparam int CSUM_W = 24;
	localparam int SUM_W  = 17;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = 2;
	localparam int RQ_CNT_W = 3;

	typedef enum logic [2:0] {
		KIND_PAYLOAD   = 3'd0,
		KIND_HEADER    = 3'd1,
		KIND_END       = 3'd2,
		KIND_BAD_SUM   = 3'd3,
		KIND_EARLY_END = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_HALT    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		OCT_SKIP   = 2'd0,
		OCT_DIGITS = 2'd1,
		OCT_DONE   = 2'd2
	} oct_step_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        payload_byte;
		logic [SIZE_W-1:0] file_size;
		logic              last_of_file;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} rq_push_t;

endpackage

### hw/rtl/tsd_oct.sv
// Octal field accumulator: skips leading non-digits, shifts in octal digits,
// stops at the first non-digit. Uses tsd_pkg.
`timescale 1ns / 1ps

module tsd_oct #(
	parameter int ACC_W = tsd_pkg::CSUM_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             clr,
	input  logic [7:0]       data_byte,
	output logic [ACC_W-1:0] acc_d
);

	logic [ACC_W-1:0]   acc_q;
	tsd_pkg::oct_step_t step_q, step_d;
	logic               is_digit;
	logic [2:0]         digit;

	assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h37);
	assign digit    = data_byte[2:0];

	always_comb begin
		acc_d  = acc_q;
		step_d = step_q;
		if (en) begin
			case (step_q)
				tsd_pkg::OCT_SKIP: begin
					if (is_digit) begin
						step_d = tsd_pkg::OCT_DIGITS;
						acc_d  = ACC_W'(digit);
					end
				end
				tsd_pkg::OCT_DIGITS: begin
					if (is_digit) begin
						acc_d = {acc_q[ACC_W-4:0], digit};
					end else begin
						step_d = tsd_pkg::OCT_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			step_q <= tsd_pkg::OCT_SKIP;
		end else if (clr) begin
			acc_q  <= '0;
			step_q <= tsd_pkg::OCT_SKIP;
		end else begin
			acc_q  <= acc_d;
			step_q <= step_d;
		end
	end

endmodule

### hw/rtl/tsd_rq.sv
// Result queue: four entries, up to two pushes and one pop per cycle.
// Uses tsd_pkg for the result and push structs.
`timescale 1ns / 1ps

module tsd_rq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsd_pkg::rq_push_t            push,
	input  logic                         pop,
	output tsd_pkg::res_t                head,
	output logic                         valid,
	output logic [tsd_pkg::RQ_CNT_W-1:0] count
);

	tsd_pkg::res_t                ent_q [tsd_pkg::RQ_DEPTH];
	logic [tsd_pkg::RQ_PTR_W-1:0] wr_q, rd_q;
	logic [tsd_pkg::RQ_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[tsd_pkg::RQ_PTR_W'(wr_q + 1'b1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + tsd_pkg::RQ_PTR_W'(push.n);
			rd_q  <= rd_q + tsd_pkg::RQ_PTR_W'(pop);
			cnt_q <= cnt_q + tsd_pkg::RQ_CNT_W'(push.n) - tsd_pkg::RQ_CNT_W'(pop);
		end
	end

	assign head  = ent_q[rd_q];
	assign valid = (cnt_q != '0);
	assign count = cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tsd_pkg::RQ_CNT_W'(tsd_pkg::RQ_DEPTH))
		else $error("result queue count exceeds depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("result queue popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> cnt_q <= tsd_pkg::RQ_CNT_W'(tsd_pkg::RQ_DEPTH - 2))
		else $error("result queue pushed without room for two");

endmodule

### hw/rtl/tar_stream_deframer_core.sv
// Tar stream deframer: parses ustar header blocks and passes file payload.
// Uses tsd_pkg, tsd_oct and tsd_rq.
`timescale 1ns / 1ps

// Usage:
// The item channel carries one archive byte per transfer, with stream_end
// set on the final byte of the input. The result channel carries header,
// payload, end-of-archive and error results; last marks the final result
// caused by one input byte, and one byte causes at most two results.
// An accepted byte is held in an input register, then processed into a
// four-entry result queue once the queue has room; its results are registered
// in the queue before they transfer. One byte is taken per cycle while
// item_stall is low; the two results of a byte that causes two leave one at a
// time through the single read port of the result queue.
// Reset clears the queue and returns the parser to the start of a header
// block. After end of archive, a checksum failure or an early stream end
// the parser halts: bytes are still taken but give no results until reset.
// While the receiver stalls, results wait in the queue; once the queue
// cannot take two more results the held byte waits and item_stall rises.

module tar_stream_deframer_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  tsd_pkg::item_t item,
	output logic           result_valid,
	input  logic           result_stall,
	output tsd_pkg::res_t  result
);

	tsd_pkg::item_t item_s1;
	logic           valid_s1;
	logic           take_in, consume, room;

	logic [tsd_pkg::OFF_W-1:0]  off_q;
	logic [tsd_pkg::SUM_W-1:0]  bsum_q, bsum_d;
	logic                       zero_q, zero_d;
	logic [tsd_pkg::SIZE_W-1:0] remain_q;
	tsd_pkg::phase_t            phase_q, phase_mid, phase_d;

	logic [7:0]                 b;
	logic                       hdr, pay, act, block_done, in_csum, in_size, mismatch;
	logic                       early;
	logic [tsd_pkg::SIZE_W-1:0] size_acc;
	logic [tsd_pkg::CSUM_W-1:0] csum_acc;

	logic                         prim_v;
	tsd_pkg::res_t                prim, early_res;
	tsd_pkg::rq_push_t            push;
	logic                         pop;
	logic [tsd_pkg::RQ_CNT_W-1:0] rq_cnt;

	assign room       = rq_cnt <= tsd_pkg::RQ_CNT_W'(tsd_pkg::RQ_DEPTH - 2);
	assign consume    = valid_s1 && room;
	assign item_stall = valid_s1 && !consume;
	assign take_in    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
	end

	assign b          = item_s1.data_byte;
	assign hdr        = (phase_q == tsd_pkg::PH_HEADER);
	assign pay        = (phase_q == tsd_pkg::PH_PAYLOAD);
	assign act        = consume && (hdr || pay);
	assign block_done = (off_q == tsd_pkg::OFF_W'(tsd_pkg::BLOCK_LEN - 1));
	assign in_csum    = (off_q >= tsd_pkg::OFF_W'(tsd_pkg::SUM_START)) &&
	                    (off_q <= tsd_pkg::OFF_W'(tsd_pkg::SUM_END));
	assign in_size    = (off_q >= tsd_pkg::OFF_W'(tsd_pkg::SIZE_START)) &&
	                    (off_q < tsd_pkg::OFF_W'(tsd_pkg::SIZE_START + tsd_pkg::SIZE_LEN));
	assign bsum_d     = bsum_q + tsd_pkg::SUM_W'(in_csum ? tsd_pkg::SPACE_CODE : b);
	assign zero_d     = zero_q && (b == 8'h00);
	assign mismatch   = tsd_pkg::CSUM_W'(bsum_d) != csum_acc;

	tsd_oct #(.ACC_W(tsd_pkg::SIZE_W)) u_size (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (act && hdr && in_size),
		.clr       (act && hdr && block_done),
		.data_byte (b),
		.acc_d     (size_acc)
	);

	tsd_oct #(.ACC_W(tsd_pkg::CSUM_W)) u_csum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (act && hdr && in_csum),
		.clr       (act && hdr && block_done),
		.data_byte (b),
		.acc_d     (csum_acc)
	);

	// next phase
	always_comb begin
		phase_mid = phase_q;
		case (phase_q)
			tsd_pkg::PH_HEADER: begin
				if (consume && block_done) begin
					if (zero_d || mismatch) begin
						phase_mid = tsd_pkg::PH_HALT;
					end else if (size_acc != '0) begin
						phase_mid = tsd_pkg::PH_PAYLOAD;
					end
				end
			end
			tsd_pkg::PH_PAYLOAD: begin
				if (consume && block_done &&
				    (remain_q == '0 || remain_q == tsd_pkg::SIZE_W'(1))) begin
					phase_mid = tsd_pkg::PH_HEADER;
				end
			end
			default: begin
				phase_mid = tsd_pkg::PH_HALT;
			end
		endcase
		early   = act && item_s1.stream_end && (phase_mid != tsd_pkg::PH_HALT);
		phase_d = early ? tsd_pkg::PH_HALT : phase_mid;
	end

	// results
	always_comb begin
		prim_v = 1'b0;
		prim   = '0;
		case (phase_q)
			tsd_pkg::PH_HEADER: begin
				if (consume && block_done) begin
					prim_v = 1'b1;
					if (zero_d) begin
						prim.kind = tsd_pkg::KIND_END;
					end else if (mismatch) begin
						prim.kind = tsd_pkg::KIND_BAD_SUM;
					end else begin
						prim.kind      = tsd_pkg::KIND_HEADER;
						prim.file_size = size_acc;
					end
				end
			end
			tsd_pkg::PH_PAYLOAD: begin
				if (consume && remain_q != '0) begin
					prim_v            = 1'b1;
					prim.kind         = tsd_pkg::KIND_PAYLOAD;
					prim.payload_byte = b;
					prim.last_of_file = (remain_q == tsd_pkg::SIZE_W'(1));
				end
			end
			default: begin
			end
		endcase
		prim.last = !early;

		early_res      = '0;
		early_res.kind = tsd_pkg::KIND_EARLY_END;
		early_res.last = 1'b1;

		push.n  = 2'(prim_v) + 2'(early);
		push.r0 = prim_v ? prim : early_res;
		push.r1 = early_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tsd_pkg::PH_HEADER;
			off_q    <= '0;
			bsum_q   <= '0;
			zero_q   <= 1'b1;
			remain_q <= '0;
		end else begin
			if (consume) begin
				phase_q <= phase_d;
			end
			if (act) begin
				off_q <= block_done ? '0 : off_q + 1'b1;
				if (hdr) begin
					if (block_done) begin
						bsum_q <= '0;
						zero_q <= 1'b1;
						if (!zero_d && !mismatch) begin
							remain_q <= size_acc;
						end
					end else begin
						bsum_q <= bsum_d;
						zero_q <= zero_d;
					end
				end else if (remain_q != '0) begin
					remain_q <= remain_q - 1'b1;
				end
			end
		end
	end

	assign pop = result_valid && !result_stall;

	tsd_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (result),
		.valid  (result_valid),
		.count  (rq_cnt)
	);

endmodule

### bench/tsd_result_checker.sv
// Result checker for the tar stream deframer: watches both channels, predicts
// the results of every byte transfer and compares them field by field.
// Uses tsd_pkg.
`timescale 1ns / 1ps

module tsd_result_checker
	import tsd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  logic  item_stall,
	input  item_t item,
	input  logic  result_valid,
	input  logic  result_stall,
	input  res_t  result,
	output int    fails,
	output int    waiting,
	output int    headers_seen,
	output int    data_seen
);

	typedef struct packed {
		oct_step_t         st;
		logic [SIZE_W-1:0] acc;
	} oct_state_t;

	phase_t            phase;
	logic [OFF_W-1:0]  offset;
	logic [SUM_W-1:0]  hdr_sum;
	logic              hdr_zero;
	oct_state_t        size_oct;
	oct_state_t        csum_oct;
	logic [SIZE_W-1:0] remaining;
	res_t              awaited[$];
	int                mismatches;
	int                hdr_count;
	int                data_count;

	function automatic oct_state_t octal_advance(oct_state_t cur, logic [7:0] b);
		oct_state_t nxt;
		logic       digit;
		nxt = cur;
		digit = (b >= "0") && (b <= "7");
		if (cur.st == OCT_SKIP && digit) begin
			nxt.st = OCT_DIGITS;
			nxt.acc = SIZE_W'(b[2:0]);
		end else if (cur.st == OCT_DIGITS) begin
			if (digit)
				nxt.acc = {cur.acc[SIZE_W-4:0], b[2:0]};
			else
				nxt.st = OCT_DONE;
		end
		return nxt;
	endfunction

	function automatic res_t result_of(kind_t k, logic [7:0] pb, logic [SIZE_W-1:0] fs,
			logic lof);
		res_t r;
		r.kind = k;
		r.payload_byte = pb;
		r.file_size = fs;
		r.last_of_file = lof;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic clear_header();
		hdr_sum = '0;
		hdr_zero = 1'b1;
		size_oct = '{st: OCT_SKIP, acc: '0};
		csum_oct = '{st: OCT_SKIP, acc: '0};
	endtask

	task automatic deframe_byte(item_t it);
		logic [OFF_W-1:0] off;
		logic             done;
		logic             in_sum;
		res_t             outs[2];
		int               n;
		n = 0;
		if (phase != PH_HEADER && phase != PH_PAYLOAD)
			return;
		off = offset;
		done = (off == OFF_W'(BLOCK_LEN - 1));
		if (phase == PH_HEADER) begin
			in_sum = (off >= SUM_START) && (off <= SUM_END);
			hdr_sum = hdr_sum + (in_sum ? SPACE_CODE : it.data_byte);
			if (it.data_byte != 8'h00)
				hdr_zero = 1'b0;
			if (off >= SIZE_START && off < SIZE_START + SIZE_LEN)
				size_oct = octal_advance(size_oct, it.data_byte);
			if (in_sum)
				csum_oct = octal_advance(csum_oct, it.data_byte);
			if (done) begin
				if (hdr_zero) begin
					outs[n] = result_of(KIND_END, 8'h00, '0, 1'b0);
					phase = PH_HALT;
				end else if (hdr_sum != csum_oct.acc[CSUM_W-1:0]) begin
					outs[n] = result_of(KIND_BAD_SUM, 8'h00, '0, 1'b0);
					phase = PH_HALT;
				end else begin
					outs[n] = result_of(KIND_HEADER, 8'h00, size_oct.acc, 1'b0);
					remaining = size_oct.acc;
					if (remaining != '0)
						phase = PH_PAYLOAD;
				end
				n = n + 1;
				clear_header();
			end
		end else begin
			if (remaining != '0) begin
				outs[n] = result_of(KIND_PAYLOAD, it.data_byte, '0, remaining == 1);
				n = n + 1;
				remaining = remaining - 1'b1;
			end
			if (done && remaining == '0)
				phase = PH_HEADER;
		end
		offset = done ? '0 : off + 1'b1;
		if (it.stream_end && phase != PH_HALT) begin
			outs[n] = result_of(KIND_EARLY_END, 8'h00, '0, 1'b0);
			n = n + 1;
			phase = PH_HALT;
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				outs[i].last = 1'b1;
			awaited.push_back(outs[i]);
		end
	endtask

	task automatic compare_field(string name, logic [SIZE_W-1:0] want,
			logic [SIZE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(res_t got);
		res_t want;
		if (awaited.size() == 0) begin
			$error("result with nothing awaited: kind %0d", got.kind);
			mismatches++;
		end else begin
			want = awaited.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("payload_byte", want.payload_byte, got.payload_byte);
			compare_field("file_size", want.file_size, got.file_size);
			compare_field("last_of_file", want.last_of_file, got.last_of_file);
			compare_field("last", want.last, got.last);
		end
		if (got.kind == KIND_HEADER)
			hdr_count++;
		if (got.kind == KIND_PAYLOAD)
			data_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_HEADER;
			offset = '0;
			remaining = '0;
			clear_header();
			awaited.delete();
			mismatches = 0;
			hdr_count = 0;
			data_count = 0;
		end else begin
			if (item_valid && !item_stall)
				deframe_byte(item);
			if (result_valid && !result_stall)
				check_result(result);
		end
		fails <= mismatches;
		waiting <= awaited.size();
		headers_seen <= hdr_count;
		data_seen <= data_count;
	end

endmodule

### bench/tar_stream_deframer_core_tb.sv
// Testbench top for tar_stream_deframer_core: builds tar archives with
// checksummed headers, drives them with random idling and gives the verdict.
// Uses tsd_pkg, the core and tsd_result_checker.
`timescale 1ns / 1ps

module tar_stream_deframer_core_tb;
	import tsd_pkg::*;

	typedef enum int {SUM_GOOD, SUM_WRONG, SUM_BLANK} sum_form_t;
	typedef enum int {
		CLOSE_ZERO, CLOSE_ZERO_END, CLOSE_BAD_SUM, CLOSE_BLANK_SUM_END,
		CLOSE_END_IN_HEADER, CLOSE_END_ON_HEADER, CLOSE_END_IN_DATA, CLOSE_END_HUGE
	} close_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  item_valid;
	logic  item_stall;
	item_t item;
	logic  result_valid;
	logic  result_stall;
	res_t  result;

	int fails;
	int waiting;
	int headers_seen;
	int data_seen;

	logic [7:0] hdr [BLOCK_LEN];
	int         sent;
	int         files;
	int         end_at;
	int         gap_pct;
	int         stall_pct;
	bit         calm;
	close_t     closing;

	always #4 clk = ~clk;

	tar_stream_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	tsd_result_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.fails(fails),
		.waiting(waiting),
		.headers_seen(headers_seen),
		.data_seen(data_seen)
	);

	function automatic logic [7:0] non_octal();
		logic [7:0] c;
		case ($urandom_range(0, 2))
			0: return 8'h00;
			1: return 8'h20;
			default: begin
				c = 8'($urandom);
				while (c >= "0" && c <= "7")
					c = 8'($urandom);
				return c;
			end
		endcase
	endfunction

	task automatic put_octal(input int base, input int len, input logic [SIZE_W-1:0] value,
			input bit blank);
		int                nd;
		int                ndig;
		int                lead;
		int                pos;
		logic [SIZE_W-1:0] v;
		pos = base;
		if (blank) begin
			while (pos < base + len) begin
				hdr[pos] = non_octal();
				pos++;
			end
			return;
		end
		nd = 1;
		v = value >> 3;
		while (v != '0) begin
			nd++;
			v = v >> 3;
		end
		ndig = $urandom_range(len, nd);
		lead = (ndig < len) ? $urandom_range(len - ndig, 0) : 0;
		repeat (lead) begin
			hdr[pos] = non_octal();
			pos++;
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			hdr[pos] = "0" + 8'((value >> (3 * i)) & 'h7);
			pos++;
		end
		if (pos < base + len) begin
			hdr[pos] = non_octal();
			pos++;
		end
		while (pos < base + len) begin
			hdr[pos] = 8'($urandom);
			pos++;
		end
	endtask

	task automatic build_header(input logic [SIZE_W-1:0] size, input bit blank_size,
			input sum_form_t form);
		int total;
		for (int i = 0; i < BLOCK_LEN; i++)
			hdr[i] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
		hdr[0] = 8'h61 + 8'($urandom_range(0, 25));
		put_octal(SIZE_START, SIZE_LEN, size, blank_size);
		total = 8 * SPACE_CODE;
		for (int i = 0; i < BLOCK_LEN; i++)
			if (i < SUM_START || i > SUM_END)
				total += hdr[i];
		case (form)
			SUM_GOOD:  put_octal(SUM_START, SUM_END - SUM_START + 1, SIZE_W'(total), 1'b0);
			SUM_WRONG: put_octal(SUM_START, SUM_END - SUM_START + 1,
					SIZE_W'(total ^ (1 << $urandom_range(0, 16))), 1'b0);
			default:   put_octal(SUM_START, SUM_END - SUM_START + 1, '0, 1'b1);
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		logic e;
		e = (sent == end_at) || (sent > end_at && $urandom_range(0, 3) == 0);
		if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: b, stream_end: e};
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic send_header();
		for (int i = 0; i < BLOCK_LEN; i++)
			send_byte(hdr[i]);
	endtask

	task automatic send_file(input int size, input bit blank_size);
		build_header(SIZE_W'(size), blank_size, SUM_GOOD);
		send_header();
		repeat (size) send_byte(8'($urandom));
		repeat ((BLOCK_LEN - size % BLOCK_LEN) % BLOCK_LEN) send_byte(8'($urandom));
		files++;
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return BLOCK_LEN;
			3: return $urandom_range(2 * BLOCK_LEN, 3 * BLOCK_LEN);
			default: return $urandom_range(1, 600);
		endcase
	endfunction

	initial begin
		#(40_000_000);
		$display("tar_stream_deframer_core_tb: FAIL");
		$finish;
	end

	// hold off the result channel in random bursts
	initial begin
		result_stall <= 1'b0;
		forever begin
			if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				result_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	initial begin
		int start;
		int s;
		int pad;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		sent = 0;
		files = 0;
		end_at = 32'h7FFF_FFFF;
		gap_pct = 0;
		stall_pct = 0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		start = sent;
		while (sent < start + 850 - BLOCK_LEN) begin
			gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 25);
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 25);
			s = pick_size();
			send_file(s, s == 0 && $urandom_range(0, 1));
		end

		calm = 1'b1;
		closing = close_t'($urandom_range(CLOSE_ZERO, CLOSE_END_HUGE));
		case (closing)
			CLOSE_ZERO, CLOSE_ZERO_END: begin
				if (closing == CLOSE_ZERO_END)
					end_at = sent + BLOCK_LEN - 1;
				repeat (BLOCK_LEN) send_byte(8'h00);
			end
			CLOSE_BAD_SUM: begin
				build_header(SIZE_W'(pick_size()), 1'b0, SUM_WRONG);
				send_header();
			end
			CLOSE_BLANK_SUM_END: begin
				end_at = sent + BLOCK_LEN - 1;
				build_header(SIZE_W'(pick_size()), 1'b0, SUM_BLANK);
				send_header();
			end
			CLOSE_END_IN_HEADER: begin
				end_at = sent + $urandom_range(0, BLOCK_LEN - 2);
				send_file(pick_size(), 1'b0);
			end
			CLOSE_END_ON_HEADER: begin
				end_at = sent + BLOCK_LEN - 1;
				send_file(pick_size(), 1'b0);
			end
			CLOSE_END_IN_DATA: begin
				s = $urandom_range(1, 600);
				pad = (BLOCK_LEN - s % BLOCK_LEN) % BLOCK_LEN;
				end_at = sent + BLOCK_LEN + $urandom_range(0, s + pad - 1);
				send_file(s, 1'b0);
			end
			default: begin
				build_header({SIZE_W{1'b1}}, 1'b0, SUM_GOOD);
				end_at = sent + BLOCK_LEN + $urandom_range(0, 39);
				send_header();
				repeat (40) send_byte(8'($urandom));
			end
		endcase

		// drive a tail the halted core must ignore
		if (end_at > sent)
			end_at = sent + $urandom_range(0, 5);
		repeat (24) send_byte(8'($urandom));
		item_valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		$display("streamed %0d archive bytes in %0d files, closed by %s", sent, files,
			closing.name());
		$display("checked %0d header transfers and %0d payload transfers",
			headers_seen, data_seen);
		if (fails == 0)
			$display("tar_stream_deframer_core_tb: PASS");
		else
			$display("tar_stream_deframer_core_tb: FAIL");
		$finish;
	end

endmodule

### files.f
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_oct.sv
hw/rtl/tsd_rq.sv
hw/rtl/tar_stream_deframer_core.sv
bench/tsd_result_checker.sv
bench/tar_stream_deframer_core_tb.sv
